// ===== rtl/core/point_segment_distance_core_assert.svh =====
`ifndef POINT_SEGMENT_DISTANCE_CORE_ASSERT_SVH
`define POINT_SEGMENT_DISTANCE_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PSD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");

// next-cycle implication, checked outside reset
`define PSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");

`endif

// ===== rtl/core/psd_pkg.sv =====
package psd_pkg;

  localparam int COORD_BITS_DEF  = 24;
  localparam int T_FRAC_BITS_DEF = 16;
  localparam int DIST_W          = 25;
  localparam int REGION_W        = 2;

  typedef enum logic [REGION_W-1:0] {
    REG_DEGEN    = 2'd0,
    REG_BEFORE   = 2'd1,
    REG_BEYOND   = 2'd2,
    REG_INTERIOR = 2'd3
  } region_t;

  // pipeline advance and the valid bit of the beat entering a cell
  typedef struct packed {
    logic en;
    logic vld;
  } psd_ctl_t;

endpackage

// ===== rtl/core/psd_div_cell.sv =====
module psd_div_cell import psd_pkg::*; #(
  parameter int W     = 54,
  parameter int QW    = 17,
  parameter int SW    = 8,
  parameter bit SHIFT = 1'b1
) (
  input  logic          clk,
  input  logic          rst,
  input  psd_ctl_t      ctl,
  input  logic [W-1:0]  rem_in,
  input  logic [W-1:0]  den_in,
  input  logic [QW-1:0] q_in,
  input  logic [SW-1:0] side_in,
  output logic          vld,
  output logic [W-1:0]  rem,
  output logic [W-1:0]  den,
  output logic [QW-1:0] q,
  output logic [SW-1:0] side
);

  logic [W:0]    sh;
  logic [W:0]    diff;
  logic          ge;
  logic [W-1:0]  rem_next;
  logic [QW-1:0] q_next;

  // one restoring quotient bit per cell
  always_comb begin
    sh       = SHIFT ? {rem_in, 1'b0} : {1'b0, rem_in};
    ge       = sh >= {1'b0, den_in};
    diff     = sh - {1'b0, den_in};
    rem_next = ge ? diff[W-1:0] : sh[W-1:0];
    q_next   = {q_in[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ctl.en) begin
      vld <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      rem  <= rem_next;
      den  <= den_in;
      q    <= q_next;
      side <= side_in;
    end
  end

endmodule

// ===== rtl/core/psd_sqrt_cell.sv =====
module psd_sqrt_cell import psd_pkg::*; #(
  parameter int W  = 54,
  parameter int RW = 27,
  parameter int K  = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  psd_ctl_t            ctl,
  input  logic [W-1:0]        rem_in,
  input  logic [RW-1:0]       root_in,
  input  logic [REGION_W-1:0] side_in,
  output logic                vld,
  output logic [W-1:0]        rem,
  output logic [RW-1:0]       root,
  output logic [REGION_W-1:0] side
);

  logic [W+1:0]  trial;
  logic          ge;
  logic [W-1:0]  rem_next;
  logic [RW-1:0] root_next;

  // (root + 2^k)^2 - root^2 = root*2^(k+1) + 2^(2k)
  always_comb begin
    trial     = ((W+2)'(root_in) << (K + 1)) + ((W+2)'(1) << (2 * K));
    ge        = {2'b00, rem_in} >= trial;
    rem_next  = ge ? (rem_in - trial[W-1:0]) : rem_in;
    root_next = ge ? (root_in | (RW'(1) << K)) : root_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ctl.en) begin
      vld <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      rem  <= rem_next;
      root <= root_next;
      side <= side_in;
    end
  end

endmodule

// ===== rtl/core/point_segment_distance_core.sv =====
// the path from input to result holds one divider cell per quotient bit, one square root cell per root bit
// and seven stages of difference, product and sum logic
// throughput: one beat per cycle; the whole chain holds only while a result waits on result_ready
// reset: synchronous active-high rst clears every valid bit; payload registers are not reset
module point_segment_distance_core import psd_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] point_z,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] start_z,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic signed [COORD_BITS-1:0] end_z,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic [DIST_W-1:0]            distance,
  output logic [REGION_W-1:0]          region
);

  `include "point_segment_distance_core_assert.svh"

  localparam int DW  = COORD_BITS + 1;
  localparam int SQW = 2 * COORD_BITS + 6;
  localparam int QW  = T_FRAC_BITS + 1;
  localparam int RW  = SQW / 2;
  localparam int RDW = COORD_BITS + 2;
  localparam int PW  = QW + 1 + DW;
  localparam int SW  = REGION_W + SQW + 6 * DW;

  logic en;
  assign en         = !result_valid || result_ready;
  assign item_ready = en;

  // stage 1: differences
  logic                 v1;
  logic signed [DW-1:0] e1 [3];
  logic signed [DW-1:0] w1 [3];
  logic signed [DW-1:0] u1 [3];
  logic signed [DW-1:0] pp [3];
  logic signed [DW-1:0] aa [3];
  logic signed [DW-1:0] bb [3];

  always_comb begin
    pp[0] = DW'(point_x); pp[1] = DW'(point_y); pp[2] = DW'(point_z);
    aa[0] = DW'(start_x); aa[1] = DW'(start_y); aa[2] = DW'(start_z);
    bb[0] = DW'(end_x);   bb[1] = DW'(end_y);   bb[2] = DW'(end_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= bb[i] - aa[i];
        w1[i] <= pp[i] - aa[i];
        u1[i] <= pp[i] - bb[i];
      end
    end
  end

  // stage 2: products
  logic                   v2;
  logic signed [2*DW-1:0] ee2 [3];
  logic signed [2*DW-1:0] ww2 [3];
  logic signed [2*DW-1:0] uu2 [3];
  logic signed [2*DW-1:0] we2 [3];
  logic signed [DW-1:0]   e2 [3];
  logic signed [DW-1:0]   w2 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ee2[i] <= e1[i] * e1[i];
        ww2[i] <= w1[i] * w1[i];
        uu2[i] <= u1[i] * u1[i];
        we2[i] <= w1[i] * e1[i];
        e2[i]  <= e1[i];
        w2[i]  <= w1[i];
      end
    end
  end

  // stage 3: sums and case selection
  logic signed [SQW-1:0] l2_sum, d_sum, sqw_sum, squ_sum;
  region_t               region_next;

  always_comb begin
    l2_sum  = SQW'(ee2[0]) + SQW'(ee2[1]) + SQW'(ee2[2]);
    d_sum   = SQW'(we2[0]) + SQW'(we2[1]) + SQW'(we2[2]);
    sqw_sum = SQW'(ww2[0]) + SQW'(ww2[1]) + SQW'(ww2[2]);
    squ_sum = SQW'(uu2[0]) + SQW'(uu2[1]) + SQW'(uu2[2]);
    if (l2_sum == '0) begin
      region_next = REG_DEGEN;
    end else if (d_sum[SQW-1]) begin
      region_next = REG_BEFORE;
    end else if (d_sum > l2_sum) begin
      region_next = REG_BEYOND;
    end else begin
      region_next = REG_INTERIOR;
    end
  end

  logic                 v3;
  logic [SQW-1:0]       l2_3, d_3, sqa_3;
  region_t              region_3;
  logic signed [DW-1:0] e3 [3];
  logic signed [DW-1:0] w3 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l2_3     <= l2_sum;
      d_3      <= d_sum;
      sqa_3    <= (region_next == REG_BEYOND) ? squ_sum : sqw_sum;
      region_3 <= region_next;
      for (int i = 0; i < 3; i++) begin
        e3[i] <= e2[i];
        w3[i] <= w2[i];
      end
    end
  end

  // divider chain: t = floor(d * 2^T / l2)
  logic           div_vld  [QW+1];
  logic [SQW-1:0] div_rem  [QW+1];
  logic [SQW-1:0] div_den  [QW+1];
  logic [QW-1:0]  div_q    [QW+1];
  logic [SW-1:0]  div_side [QW+1];

  assign div_vld[0]  = v3;
  assign div_rem[0]  = d_3;
  assign div_den[0]  = l2_3;
  assign div_q[0]    = '0;
  assign div_side[0] = {region_3, sqa_3, e3[2], e3[1], e3[0], w3[2], w3[1], w3[0]};

  for (genvar j = 0; j < QW; j++) begin : g_div
    psd_div_cell #(
      .W(SQW), .QW(QW), .SW(SW), .SHIFT(j != 0)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     ('{en: en, vld: div_vld[j]}),
      .rem_in  (div_rem[j]),
      .den_in  (div_den[j]),
      .q_in    (div_q[j]),
      .side_in (div_side[j]),
      .vld     (div_vld[j+1]),
      .rem     (div_rem[j+1]),
      .den     (div_den[j+1]),
      .q       (div_q[j+1]),
      .side    (div_side[j+1])
    );
  end

  logic [REGION_W-1:0]  region_d;
  logic [SQW-1:0]       sqa_d;
  logic signed [DW-1:0] e_d [3];
  logic signed [DW-1:0] w_d [3];

  assign {region_d, sqa_d, e_d[2], e_d[1], e_d[0], w_d[2], w_d[1], w_d[0]} = div_side[QW];

  // stage p1: t * e
  logic                 v5;
  logic signed [PW-1:0] prod5 [3];
  logic signed [DW-1:0] w5 [3];
  logic [REGION_W-1:0]  region_5;
  logic [SQW-1:0]       sqa_5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= div_vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod5[i] <= $signed({1'b0, div_q[QW]}) * e_d[i];
        w5[i]    <= w_d[i];
      end
      region_5 <= region_d;
      sqa_5    <= sqa_d;
    end
  end

  // stage p2: offset from the query point to the projection
  logic                  v6;
  logic signed [RDW-1:0] r6 [3];
  logic signed [PW-1:0]  shifted [3];
  logic [REGION_W-1:0]   region_6;
  logic [SQW-1:0]        sqa_6;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shifted[i] = prod5[i] >>> T_FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        r6[i] <= RDW'(shifted[i]) - RDW'(w5[i]);
      end
      region_6 <= region_5;
      sqa_6    <= sqa_5;
    end
  end

  // stage p3: squares of the offset
  logic                    v7;
  logic signed [2*RDW-1:0] rr7 [3];
  logic [REGION_W-1:0]     region_7;
  logic [SQW-1:0]          sqa_7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rr7[i] <= r6[i] * r6[i];
      end
      region_7 <= region_6;
      sqa_7    <= sqa_6;
    end
  end

  // stage p4: squared distance for the root chain
  logic                v8;
  logic [SQW-1:0]      sq8;
  logic [REGION_W-1:0] region_8;
  logic [SQW-1:0]      sqr_sum;

  assign sqr_sum = SQW'(rr7[0]) + SQW'(rr7[1]) + SQW'(rr7[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq8      <= (region_t'(region_7) == REG_INTERIOR) ? sqr_sum : sqa_7;
      region_8 <= region_7;
    end
  end

  // square root chain, one root bit per cell from the top
  logic                sq_vld  [RW+1];
  logic [SQW-1:0]      sq_rem  [RW+1];
  logic [RW-1:0]       sq_root [RW+1];
  logic [REGION_W-1:0] sq_side [RW+1];

  assign sq_vld[0]  = v8;
  assign sq_rem[0]  = sq8;
  assign sq_root[0] = '0;
  assign sq_side[0] = region_8;

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    psd_sqrt_cell #(
      .W(SQW), .RW(RW), .K(RW - 1 - j)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     ('{en: en, vld: sq_vld[j]}),
      .rem_in  (sq_rem[j]),
      .root_in (sq_root[j]),
      .side_in (sq_side[j]),
      .vld     (sq_vld[j+1]),
      .rem     (sq_rem[j+1]),
      .root    (sq_root[j+1]),
      .side    (sq_side[j+1])
    );
  end

  assign result_valid = sq_vld[RW];
  assign distance     = DIST_W'(sq_root[RW]);
  assign region       = sq_side[RW];

  `PSD_ASSERT_NOW(a_stall_only_when_blocked, !item_ready, result_valid && !result_ready)
  `PSD_ASSERT_NEXT(a_case_beat_enters_divider, en && v3, div_vld[1])
  `PSD_ASSERT_NEXT(a_sums_hold_on_stall, !en, $stable(l2_3) && $stable(region_3))
  `PSD_ASSERT_NEXT(a_root_beat_moves, en && v8, sq_vld[1])

endmodule
